/* hdl/mrpt_pkg.sv */
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared types, constants and base tables for the primality test core
// ----------------------------------------------------------------------------
package mrpt_pkg;

   localparam int unsigned WordWidth   = 64;
   localparam int unsigned QueueDepth  = 2;
   localparam int unsigned BaseIdxBits = 4;

   localparam logic [63:0] LimA = 64'd9080191;
   localparam logic [63:0] LimB = 64'd4759123141;
   localparam logic [63:0] LimC = 64'd1122004669633;
   localparam logic [63:0] BigBase = 64'd1662803;
   localparam logic [63:0] LimD = 64'd2152302898747;
   localparam logic [63:0] LimE = 64'd3474749660383;
   localparam logic [63:0] LimF = 64'd341550071728321;
   localparam logic [63:0] LimG = 64'd3825123056546413051;

   // item class decided by the front end
   typedef enum logic [2:0] {
      CLS_FALSE,
      CLS_TRUE,
      CLS_RANGE_A,
      CLS_RANGE_B,
      CLS_RANGE_C,
      CLS_RANGE_G
   } cls_type;

   typedef struct packed {
      logic [63:0] n;
      cls_type     cls;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_LOAD,
      ST_REDUCE,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_POW_NEXT,
      ST_CHECK,
      ST_SQR,
      ST_SQR_CHECK,
      ST_NEXT_BASE,
      ST_DONE
   } st_type;

   // base of round idx for a class; zero marks the end of the list
   function automatic logic [63:0] base_of(cls_type cls, logic [BaseIdxBits-1:0] idx);
      logic [63:0] b;
      b = 64'd0;
      case (cls)
         CLS_RANGE_A: begin
            case (idx)
               4'd0: b = 64'd31;
               4'd1: b = 64'd73;
               default: b = 64'd0;
            endcase
         end
         CLS_RANGE_B: begin
            case (idx)
               4'd0: b = 64'd7;
               4'd1: b = 64'd2;
               4'd2: b = 64'd61;
               default: b = 64'd0;
            endcase
         end
         CLS_RANGE_C: begin
            case (idx)
               4'd0: b = 64'd13;
               4'd1: b = 64'd2;
               4'd2: b = 64'd23;
               4'd3: b = BigBase;
               default: b = 64'd0;
            endcase
         end
         CLS_RANGE_G: begin
            case (idx)
               4'd0:  b = 64'd11;
               4'd1:  b = 64'd7;
               4'd2:  b = 64'd5;
               4'd3:  b = 64'd3;
               4'd4:  b = 64'd2;
               4'd5:  b = 64'd13;
               4'd6:  b = 64'd17;
               4'd7:  b = 64'd19;
               4'd8:  b = 64'd23;
               4'd9:  b = 64'd29;
               4'd10: b = 64'd31;
               4'd11: b = 64'd37;
               default: b = 64'd0;
            endcase
         end
         default: b = 64'd0;
      endcase
      return b;
   endfunction

   // number of bases actually used by a wide-range candidate
   function automatic logic [BaseIdxBits-1:0] g_count(logic [63:0] n);
      logic [BaseIdxBits-1:0] c;
      if (n < LimD) c = 4'd5;
      else if (n < LimE) c = 4'd6;
      else if (n < LimF) c = 4'd7;
      else if (n < LimG) c = 4'd9;
      else c = 4'd12;
      return c;
   endfunction

endpackage

/* hdl/mrpt_modmul.sv */
// ----------------------------------------------------------------------------
// mrpt_modmul
// shift-and-add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mrpt_modmul
   import mrpt_pkg::*;
#(
   parameter int unsigned Width = WordWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [Width-1:0] x,
   input  logic [Width-1:0] y,
   input  logic [Width-1:0] m,
   output logic             done,
   output logic [Width-1:0] prod
);

   localparam int unsigned CntBits = $clog2(Width);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [Width-1:0]   acc_ff, acc_in;
   logic [Width-1:0]   x_ff, x_in;
   logic [Width-1:0]   y_ff, y_in;
   logic [Width-1:0]   m_ff, m_in;
   logic [Width-1:0]   dbl;
   logic [Width-1:0]   gap_a;
   logic [Width-1:0]   gap_x;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      gap_a   = m_ff - acc_ff;
      dbl     = (acc_ff >= gap_a) ? (acc_ff - gap_a) : (acc_ff + acc_ff);
      gap_x   = m_ff - x_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         m_in    = m;
      end else if (busy_ff) begin
         acc_in = dbl;
         if (y_ff[Width-1]) begin
            acc_in = (dbl >= gap_x) ? (dbl - gap_x) : (dbl + x_ff);
         end
         y_in   = {y_ff[Width-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

/* hdl/mrpt_front.sv */
// ----------------------------------------------------------------------------
// mrpt_front
// accepts candidates, settles trivial ones and picks the base set
// ----------------------------------------------------------------------------
module mrpt_front
   import mrpt_pkg::*;
(
   input  logic        start,
   input  logic [63:0] candidate,
   output logic        busy,
   output logic        push,
   output job_type     job,
   input  logic        full
);

   cls_type cls;

   always_comb begin
      if (candidate < 64'd2) cls = CLS_FALSE;
      else if (candidate == 64'd2) cls = CLS_TRUE;
      else if (!candidate[0]) cls = CLS_FALSE;
      else if (candidate < LimA) begin
         if (candidate == 64'd31 || candidate == 64'd73) cls = CLS_TRUE;
         else cls = CLS_RANGE_A;
      end
      else if (candidate < LimB) cls = CLS_RANGE_B;
      else if (candidate < LimC) cls = CLS_RANGE_C;
      else cls = CLS_RANGE_G;
   end

   assign busy    = full;
   assign push    = start && !full;
   assign job.n   = candidate;
   assign job.cls = cls;

endmodule

/* hdl/mrpt_queue.sv */
// ----------------------------------------------------------------------------
// mrpt_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module mrpt_queue
   import mrpt_pkg::*;
#(
   parameter int unsigned Depth = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;

   job_type            mem_ff [Depth];
   logic [PtrBits-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrBits:0]   cnt_ff, cnt_in;

   function automatic logic [PtrBits-1:0] inc(logic [PtrBits-1:0] p);
      return (p == PtrBits'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_in  = (push && !full) ? inc(wr_ff) : wr_ff;
      rd_in  = (pop && !empty) ? inc(rd_ff) : rd_ff;
      cnt_in = cnt_ff + (PtrBits+1)'(push && !full) - (PtrBits+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) mem_ff[wr_ff] <= push_job;
   end

   assign head  = mem_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PtrBits+1)'(Depth));

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PtrBits+1)'(Depth))
      else $error("queue count over depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |=> (cnt_ff <= 1))
      else $error("queue count jumped from empty");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> full)
      else $error("queue lost an item while full");

endmodule

/* hdl/mrpt_back.sv */
// ----------------------------------------------------------------------------
// mrpt_back
// runs strong probable prime rounds over the base set of each item
// ----------------------------------------------------------------------------
module mrpt_back
   import mrpt_pkg::*;
#(
   parameter int unsigned Width = WordWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  job_type          head,
   output logic             pop,
   output logic             rsp_valid,
   output logic             rsp_is_prime
);

   localparam int unsigned KBits = $clog2(Width) + 1;

   st_type                 st_ff, st_in;
   logic [Width-1:0]       n_ff, n_in;
   cls_type                cls_ff, cls_in;
   logic [Width-1:0]       q_ff, q_in;
   logic [KBits-1:0]       k_ff, k_in;
   logic [KBits-1:0]       r_ff, r_in;
   logic [Width-1:0]       e_ff, e_in;
   logic [Width-1:0]       b_ff, b_in;
   logic [Width-1:0]       x_ff, x_in;
   logic [BaseIdxBits-1:0] bi_ff, bi_in;
   logic [BaseIdxBits-1:0] nb_ff, nb_in;
   logic                   out_v_ff, out_v_in;
   logic                   out_p_ff, out_p_in;
   logic                   mul_go;
   logic [Width-1:0]       mul_x, mul_y;
   logic                   mul_done;
   logic [Width-1:0]       mul_p;
   logic [Width-1:0]       base;

   mrpt_modmul #(.Width(Width)) u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .x     (mul_x),
      .y     (mul_y),
      .m     (n_ff),
      .done  (mul_done),
      .prod  (mul_p)
   );

   assign base = base_of(cls_ff, bi_ff);

   always_comb begin
      st_in    = st_ff;
      n_in     = n_ff;
      cls_in   = cls_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      e_in     = e_ff;
      b_in     = b_ff;
      x_in     = x_ff;
      bi_in    = bi_ff;
      nb_in    = nb_ff;
      out_v_in = 1'b0;
      out_p_in = out_p_ff;
      pop      = 1'b0;
      mul_go   = 1'b0;
      mul_x    = x_ff;
      mul_y    = b_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               n_in   = head.n;
               cls_in = head.cls;
               q_in   = head.n - 1'b1;
               k_in   = '0;
               bi_in  = '0;
               unique case (head.cls)
                  CLS_RANGE_A: nb_in = BaseIdxBits'(2);
                  CLS_RANGE_B: nb_in = BaseIdxBits'(3);
                  CLS_RANGE_C: nb_in = BaseIdxBits'(4);
                  default:     nb_in = g_count(head.n);
               endcase
               if (head.cls == CLS_FALSE || head.cls == CLS_TRUE) begin
                  out_p_in = (head.cls == CLS_TRUE);
                  st_in    = ST_DONE;
               end else begin
                  st_in = ST_SPLIT;
               end
            end
         end
         // one trailing zero of n-1 per cycle
         ST_SPLIT: begin
            if (q_ff[0]) st_in = ST_LOAD;
            else begin
               q_in = {1'b0, q_ff[Width-1:1]};
               k_in = k_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            b_in  = base;
            e_in  = q_ff;
            x_in  = Width'(1);
            st_in = ST_REDUCE;
         end
         // small candidates can sit below the base, subtract n until it fits
         ST_REDUCE: begin
            if (b_ff >= n_ff) b_in = b_ff - n_ff;
            else st_in = ST_POW_MUL;
         end
         ST_POW_MUL: begin
            if (e_ff == '0) st_in = ST_CHECK;
            else if (e_ff[0]) begin
               mul_go = 1'b1;
               mul_x  = x_ff;
               mul_y  = b_ff;
               st_in  = ST_POW_SQR;
            end else begin
               mul_go = 1'b1;
               mul_x  = b_ff;
               mul_y  = b_ff;
               st_in  = ST_POW_NEXT;
            end
         end
         ST_POW_SQR: begin
            if (mul_done) begin
               x_in   = mul_p;
               mul_go = 1'b1;
               mul_x  = b_ff;
               mul_y  = b_ff;
               st_in  = ST_POW_NEXT;
            end
         end
         ST_POW_NEXT: begin
            if (mul_done) begin
               b_in  = mul_p;
               e_in  = {1'b0, e_ff[Width-1:1]};
               st_in = ST_POW_MUL;
            end
         end
         ST_CHECK: begin
            r_in = KBits'(1);
            if (x_ff == Width'(1) || x_ff == n_ff - 1'b1) st_in = ST_NEXT_BASE;
            else if (k_ff <= KBits'(1)) begin
               out_p_in = 1'b0;
               st_in    = ST_DONE;
            end else st_in = ST_SQR;
         end
         ST_SQR: begin
            mul_go = 1'b1;
            mul_x  = x_ff;
            mul_y  = x_ff;
            st_in  = ST_SQR_CHECK;
         end
         ST_SQR_CHECK: begin
            if (mul_done) begin
               x_in = mul_p;
               r_in = r_ff + 1'b1;
               if (mul_p == n_ff - 1'b1) st_in = ST_NEXT_BASE;
               else if (mul_p == Width'(1) || r_ff + 1'b1 >= k_ff) begin
                  out_p_in = 1'b0;
                  st_in    = ST_DONE;
               end else st_in = ST_SQR;
            end
         end
         ST_NEXT_BASE: begin
            if (bi_ff + 1'b1 >= nb_ff) begin
               out_p_in = 1'b1;
               st_in    = ST_DONE;
            end else begin
               bi_in = bi_ff + 1'b1;
               st_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            out_v_in = 1'b1;
            st_in    = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         out_v_ff <= out_v_in;
      end
      n_ff     <= n_in;
      cls_ff   <= cls_in;
      q_ff     <= q_in;
      k_ff     <= k_in;
      r_ff     <= r_in;
      e_ff     <= e_in;
      b_ff     <= b_in;
      x_ff     <= x_in;
      bi_ff    <= bi_in;
      nb_ff    <= nb_in;
      out_p_ff <= out_p_in;
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_is_prime = out_p_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (st_ff == ST_IDLE))
      else $error("queue popped while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(st_ff) == ST_DONE))
      else $error("result without done state");

endmodule

/* hdl/miller_rabin_prime_test_core.sv */
// trivial candidates go from idle straight to the done state; others first strip the
//   trailing zeros of n-1, then take about 2*64 modular products per base.
// the back end takes one item at a time, its pace set by the bit-serial multiplier;
//   the front queue holds two more items while the back end works.
// reset: synchronous active high, clears queue and sequencer; results cannot stall.
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_core
// deterministic 64-bit primality test with decoupled front end and sequencer
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_core
   import mrpt_pkg::*;
#(
   parameter int unsigned Depth = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_candidate,
   output logic        rsp_valid,
   output logic        rsp_is_prime
);

   logic    push, pop, empty, full;
   job_type job, head;

   mrpt_front u_front (
      .start     (start),
      .candidate (req_candidate),
      .busy      (busy),
      .push      (push),
      .job       (job),
      .full      (full)
   );

   mrpt_queue #(.Depth(Depth)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   mrpt_back #(.Width(WordWidth)) u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for the 64-bit primality test core: candidates are
// driven through the start/busy handshake, every verdict is predicted by an
// independent strong-probable-prime model and compared as it comes out
// ----------------------------------------------------------------------------
module tb;
   import mrpt_pkg::*;

   localparam int RandomItems = 600;
   localparam int StallLimit  = 600000;
   localparam int TailCycles  = 20;

   typedef struct {
      logic [63:0] cand;
      bit          hold_off;
   } item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_candidate = '0;
   logic        rsp_valid;
   logic        rsp_is_prime;

   item_type    pending_items[$];
   logic        verdicts_due[$];
   logic [63:0] cands_due[$];
   int          error_count = 0;
   int          sent_count = 0;
   int          total_items = 0;
   int          quiet_cycles = 0;

   miller_rabin_prime_test_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_candidate(req_candidate),
      .rsp_valid(rsp_valid),
      .rsp_is_prime(rsp_is_prime)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p % {64'd0, m});
   endfunction

   function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1 % m;
      sq = b % m;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, sq, m);
         sq = mod_mul(sq, sq, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // true when base w shows the odd n to be composite
   function automatic bit base_disproves(logic [63:0] n, logic [63:0] q, int k,
                                         logic [63:0] w);
      logic [63:0] x;
      x = mod_pow(w, q, n);
      if (x == 1 || x == n - 1) return 1'b0;
      for (int r = 1; r < k; r++) begin
         x = mod_mul(x, x, n);
         if (x == n - 1) return 1'b0;
         if (x == 1) return 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic logic prime_verdict(logic [63:0] n);
      logic [63:0] q;
      int k;
      logic [63:0] wide_bases[12];
      int used;
      wide_bases = '{64'd11, 64'd7, 64'd5, 64'd3, 64'd2, 64'd13, 64'd17, 64'd19,
                     64'd23, 64'd29, 64'd31, 64'd37};
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if (!n[0]) return 1'b0;
      q = n - 1;
      k = 0;
      while (!q[0]) begin
         q = q >> 1;
         k++;
      end
      if (n < LimA) begin
         if (n == 31 || n == 73) return 1'b1;
         return !(base_disproves(n, q, k, 31) || base_disproves(n, q, k, 73));
      end
      if (n < LimB)
         return !(base_disproves(n, q, k, 7) || base_disproves(n, q, k, 2) ||
                  base_disproves(n, q, k, 61));
      if (n < LimC)
         return !(base_disproves(n, q, k, 13) || base_disproves(n, q, k, 2) ||
                  base_disproves(n, q, k, 23) || base_disproves(n, q, k, BigBase));
      if (n < LimD) used = 5;
      else if (n < LimE) used = 6;
      else if (n < LimF) used = 7;
      else if (n < LimG) used = 9;
      else used = 12;
      for (int i = 0; i < used; i++)
         if (base_disproves(n, q, k, wide_bases[i])) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [63:0] random_candidate();
      int r;
      logic [63:0] v;
      r = $urandom_range(0, 99);
      v = {$urandom, $urandom};
      if (r < 30) return v & ~64'd1;
      if (r < 42) return 64'($urandom_range(0, 63));
      if (r < 80) return 64'($urandom_range(0, 4095)) | 64'd1;
      if (r < 93) return {32'd0, v[31:0]} | 64'd1;
      return v | 64'd1;
   endfunction

   // idle percentage for the sender, by phase of the run
   function automatic int idle_pct(int sent);
      int phase;
      phase = (total_items == 0) ? 0 : (sent * 4) / total_items;
      case (phase)
         1: return 88;
         3: return 9;
         default: return 0;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      bit taken;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            verdicts_due.push_back(prime_verdict(req_candidate));
            cands_due.push_back(req_candidate);
            void'(pending_items.pop_front());
            sent_count++;
         end
         if (!start || taken) begin
            if (pending_items.size() != 0 &&
                !(pending_items[0].hold_off && verdicts_due.size() != 0) &&
                $urandom_range(0, 99) >= idle_pct(sent_count)) begin
               start <= 1'b1;
               req_candidate <= pending_items[0].cand;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic want;
      logic [63:0] cand;
      if (!reset && rsp_valid) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected item, is_prime expected none actual %0b",
                     $time, rsp_is_prime);
            error_count++;
         end else begin
            want = verdicts_due.pop_front();
            cand = cands_due.pop_front();
            if (rsp_is_prime !== want) begin
               $display("%0t: candidate %0d is_prime expected %0b actual %0b",
                        $time, cand, want, rsp_is_prime);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [63:0] directed[$];
      item_type it;
      directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd31, 64'd73,
                   64'd97, LimA - 2, LimA, LimB, 64'd3215031751, BigBase,
                   LimC, LimD, LimE, LimF, LimG, 64'd18446744073709551557,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                   64'h8000_0000_0000_0000};
      foreach (directed[i]) begin
         it.cand = directed[i];
         it.hold_off = 1'b0;
         pending_items.push_back(it);
      end
      for (int i = 0; i < RandomItems; i++) begin
         it.cand = random_candidate();
         // drain the core completely before this item goes in
         it.hold_off = (i == RandomItems / 2);
         pending_items.push_back(it);
      end
      total_items = pending_items.size();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() != 0 || verdicts_due.size() != 0)
         @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/mrpt_pkg.sv
hdl/mrpt_modmul.sv
hdl/mrpt_front.sv
hdl/mrpt_queue.sv
hdl/mrpt_back.sv
hdl/miller_rabin_prime_test_core.sv
tb/tb.sv
